// ----- hdl/vt100_escape_key_decoder_macros.svh -----
// assertion macros for the vt100 escape key decoder
`ifndef VT100_ESCAPE_KEY_DECODER_MACROS_SVH
`define VT100_ESCAPE_KEY_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define VTKD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define VTKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/vtkd_pkg.sv -----
// shared codes and byte constants for the vt100 escape key decoder
`timescale 1ns / 1ps

package vtkd_pkg;

  localparam int unsigned KindW = 3;
  localparam int unsigned ModeW = 4;

  // result kinds
  localparam logic [KindW-1:0] KIND_CHAR  = 3'd0;
  localparam logic [KindW-1:0] KIND_UP    = 3'd1;
  localparam logic [KindW-1:0] KIND_DOWN  = 3'd2;
  localparam logic [KindW-1:0] KIND_RIGHT = 3'd3;
  localparam logic [KindW-1:0] KIND_LEFT  = 3'd4;

  // parser modes
  localparam logic [ModeW-1:0] MODE_IDLE    = 4'd0;
  localparam logic [ModeW-1:0] MODE_ESC     = 4'd1;
  localparam logic [ModeW-1:0] MODE_SKIP1   = 4'd2;
  localparam logic [ModeW-1:0] MODE_CSI_PAR = 4'd3;
  localparam logic [ModeW-1:0] MODE_CSI_INT = 4'd4;

  localparam logic [7:0] BYTE_ESC     = 8'h1b;
  localparam logic [7:0] BYTE_CSI     = 8'h5b;
  localparam logic [7:0] PARAM_LO     = 8'h30;
  localparam logic [7:0] PARAM_HI     = 8'h3f;
  localparam logic [7:0] INTER_LO     = 8'h20;
  localparam logic [7:0] INTER_HI     = 8'h2f;
  localparam logic [7:0] FINAL_UP     = 8'h41;
  localparam logic [7:0] FINAL_DOWN   = 8'h42;
  localparam logic [7:0] FINAL_RIGHT  = 8'h43;
  localparam logic [7:0] FINAL_LEFT   = 8'h44;

  typedef logic [KindW-1:0] kind_t;

endpackage

// ----- hdl/vt100_escape_key_decoder.sv -----
// vt100 escape key decoder: byte-wise escape parser with a registered result
//
//   channel | signals                          | beat
//   --------+----------------------------------+-------------------------------
//   in      | in_valid_i in_stall_o byte_in_i  | one terminal byte
//   out     | out_valid_o out_stall_i kind_o   | one character or arrow key
//           | char_out_o                       |
//
// one byte a cycle unless stalled; result on the cycle after its byte is taken
// the rate is set by the single mode register and the one-deep result register
// the input stalls only while a result is held and the output is stalled
// reset clears the mode to idle and empties the result register
`timescale 1ns / 1ps
`include "vt100_escape_key_decoder_macros.svh"

module vt100_escape_key_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vtkd_pkg::kind_t    kind_o,
  output logic [7:0]         char_out_o
);
  import vtkd_pkg::*;

  logic [ModeW-1:0] mode_q, mode_d;
  logic             out_valid_q, out_valid_d;
  kind_t            kind_q, kind_d;
  logic [7:0]       char_q, char_d;
  logic             accept;
  logic             emit;
  kind_t            emit_kind;
  logic [7:0]       emit_char;
  logic             final_hit;
  kind_t            final_kind;
  logic             key_beat;
  logic             char_beat;
  logic             plain_in;
  logic             esc_in;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // final byte of a csi sequence
  always_comb begin
    final_hit  = 1'b1;
    final_kind = KIND_UP;
    case (byte_in_i)
      FINAL_UP:    final_kind = KIND_UP;
      FINAL_DOWN:  final_kind = KIND_DOWN;
      FINAL_RIGHT: final_kind = KIND_RIGHT;
      FINAL_LEFT:  final_kind = KIND_LEFT;
      default:     final_hit  = 1'b0;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    emit      = 1'b0;
    emit_kind = KIND_CHAR;
    emit_char = 8'h00;
    case (mode_q)
      MODE_IDLE: begin
        if (byte_in_i == BYTE_ESC) begin
          mode_d = MODE_ESC;
        end else begin
          emit      = 1'b1;
          emit_char = byte_in_i;
        end
      end
      MODE_ESC: begin
        if (byte_in_i inside {8'h4e, 8'h4f, 8'h50, 8'h5c, 8'h5d, 8'h58, 8'h5e, 8'h5f}) begin
          mode_d = MODE_SKIP1;
        end else if (byte_in_i == BYTE_CSI) begin
          mode_d = MODE_CSI_PAR;
        end else begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_CSI_PAR: begin
        if (byte_in_i inside {[PARAM_LO:PARAM_HI]}) begin
          mode_d = MODE_CSI_PAR;
        end else if (byte_in_i inside {[INTER_LO:INTER_HI]}) begin
          mode_d = MODE_CSI_INT;
        end else begin
          mode_d    = MODE_IDLE;
          emit      = final_hit;
          emit_kind = final_kind;
        end
      end
      MODE_CSI_INT: begin
        if (!(byte_in_i inside {[INTER_LO:INTER_HI]})) begin
          mode_d    = MODE_IDLE;
          emit      = final_hit;
          emit_kind = final_kind;
        end
      end
      // swallow-one mode and unused codes drop the byte
      default: mode_d = MODE_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    char_d      = char_q;
    if (!out_valid_q || !out_stall_i) begin
      out_valid_d = accept & emit;
      if (accept && emit) begin
        kind_d = emit_kind;
        char_d = emit_char;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        mode_q <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    char_q <= char_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign char_out_o  = char_q;

  assign key_beat  = out_valid_o & (kind_o != KIND_CHAR);
  assign char_beat = out_valid_o & (kind_o == KIND_CHAR);
  assign plain_in  = accept & (mode_q == MODE_IDLE) & (byte_in_i != BYTE_ESC);
  assign esc_in    = accept & (mode_q == MODE_IDLE) & (byte_in_i == BYTE_ESC);

  `VTKD_ASSERT_NOW(a_key_char_zero, key_beat, char_out_o == 8'h00, "nonzero char on key beat")
  `VTKD_ASSERT_NOW(a_kind_range, out_valid_o, kind_o <= KIND_LEFT, "result kind out of range")
  `VTKD_ASSERT_NEXT(a_plain_pass, plain_in, char_beat && char_out_o == $past(byte_in_i), "char lost")
  `VTKD_ASSERT_NEXT(a_esc_opens, esc_in, mode_q == MODE_ESC, "escape did not open a sequence")
  `VTKD_ASSERT_NOW(a_stall_full, in_stall_o, out_valid_o, "stall with empty result register")

endmodule

// ----- tb/tb_vt100_escape_key_decoder.sv -----
// self-checking testbench for the vt100 escape key decoder
`timescale 1ns / 1ps

module tb_vt100_escape_key_decoder;

  import vtkd_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1600;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_LIMIT  = 2000;

  // N O P \ ] X ^ _ : each swallows exactly one following byte
  localparam logic [63:0] SKIP_INTRO = {8'h4e, 8'h4f, 8'h50, 8'h5c,
                                        8'h5d, 8'h58, 8'h5e, 8'h5f};

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } key_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] byte_in_i;
  logic       out_valid_o;
  logic       out_stall_i;
  kind_t      kind_o;
  logic [7:0] char_out_o;

  vt100_escape_key_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .byte_in_i   (byte_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .char_out_o  (char_out_o)
  );

  key_result_t          expected_keys[$];
  key_result_t          oldest_key;
  logic [ModeW-1:0]     parse_mode;
  bit                   tx_idle;
  bit                   rx_idle;
  int                   holds_asked;
  int                   errors;
  int                   bytes_sent;
  int                   results_checked;
  int                   keys_seen;
  int                   stall_cycles;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // advances the parser by one byte; returns 1 when the byte yields a key result
  function automatic bit decode_byte(input logic [7:0] b, output kind_t k,
                                     output logic [7:0] ch);
    bit hit;
    hit = 1'b0;
    k   = KIND_CHAR;
    ch  = 8'h00;
    case (parse_mode)
      MODE_IDLE: begin
        if (b == BYTE_ESC) parse_mode = MODE_ESC;
        else begin
          hit = 1'b1;
          ch  = b;
        end
      end
      MODE_ESC: begin
        parse_mode = (b == BYTE_CSI) ? MODE_CSI_PAR : MODE_IDLE;
        for (int i = 0; i < 8; i++)
          if (SKIP_INTRO[i*8 +: 8] == b) parse_mode = MODE_SKIP1;
      end
      MODE_CSI_PAR, MODE_CSI_INT: begin
        if (parse_mode == MODE_CSI_PAR && b >= PARAM_LO && b <= PARAM_HI) begin
          // parameter byte, swallowed
        end else if (b >= INTER_LO && b <= INTER_HI) begin
          parse_mode = MODE_CSI_INT;
        end else begin
          parse_mode = MODE_IDLE;
          hit = 1'b1;
          case (b)
            FINAL_UP:    k = KIND_UP;
            FINAL_DOWN:  k = KIND_DOWN;
            FINAL_RIGHT: k = KIND_RIGHT;
            FINAL_LEFT:  k = KIND_LEFT;
            default:     hit = 1'b0;
          endcase
        end
      end
      default: parse_mode = MODE_IDLE;
    endcase
    return hit;
  endfunction

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int         gap;
    kind_t      k;
    logic [7:0] ch;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    byte_in_i  = b;
    do begin
      @(posedge clk_i);
      if (in_stall_o) stall_cycles++;
    end while (in_stall_o);
    bytes_sent++;
    if (decode_byte(b, k, ch)) expected_keys.push_back(key_result_t'{k, ch});
    @(negedge clk_i);
  endtask

  // ESC [ then a few parameter and intermediate bytes and a final byte
  task automatic send_csi(input bit arrow);
    logic [7:0] b;
    send_byte(BYTE_ESC);
    send_byte(BYTE_CSI);
    repeat ($urandom_range(0, 3)) send_byte(PARAM_LO + 8'($urandom_range(0, 15)));
    repeat ($urandom_range(0, 2)) send_byte(INTER_LO + 8'($urandom_range(0, 15)));
    if (arrow) b = FINAL_UP + 8'($urandom_range(0, 3));
    else
      do b = 8'($urandom); while (b >= INTER_LO && b <= PARAM_HI);
    send_byte(b);
  endtask

  task automatic test_plain_bytes();
    send_byte(8'h00);
    send_byte(8'hff);
  endtask

  task automatic test_arrow_keys();
    send_byte(BYTE_ESC); send_byte(BYTE_CSI); send_byte(FINAL_UP);
    send_byte(BYTE_ESC); send_byte(BYTE_CSI);
    send_byte(PARAM_LO); send_byte(PARAM_HI);
    send_byte(INTER_LO); send_byte(INTER_HI);
    send_byte(FINAL_DOWN);
    send_byte(BYTE_ESC); send_byte(BYTE_CSI); send_byte(FINAL_RIGHT);
    send_byte(BYTE_ESC); send_byte(BYTE_CSI); send_byte(FINAL_LEFT);
  endtask

  task automatic test_odd_sequences();
    // parameter byte after an intermediate ends the sequence silently
    send_byte(BYTE_ESC); send_byte(BYTE_CSI); send_byte(INTER_LO); send_byte(8'h35);
    // ESC right after ESC closes the sequence, the next byte is plain
    send_byte(BYTE_ESC); send_byte(BYTE_ESC); send_byte(8'h78);
    // ESC as csi final gives nothing
    send_byte(BYTE_ESC); send_byte(BYTE_CSI); send_byte(BYTE_ESC);
    // high byte as csi final, then as a plain character
    send_byte(BYTE_ESC); send_byte(BYTE_CSI); send_byte(8'h80); send_byte(8'h80);
    // swallowed byte is ESC and must not open a sequence
    send_byte(BYTE_ESC); send_byte(SKIP_INTRO[63:56]); send_byte(BYTE_ESC);
    send_byte(FINAL_UP);
  endtask

  task automatic test_backpressure();
    logic [7:0] b;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    holds_asked++;
    repeat (40) begin
      do b = 8'($urandom); while (b == BYTE_ESC);
      send_byte(b);
    end
  endtask

  task automatic test_random_stream();
    int         target;
    logic [7:0] b;
    for (int phase = 0; phase < 4; phase++) begin
      tx_idle = (phase == 0 || phase == 2);
      rx_idle = (phase == 0 || phase == 3);
      target  = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            do b = 8'($urandom); while (b == BYTE_ESC);
            send_byte(b);
          end
          3, 4, 5: send_csi(1'b1);
          6:       send_csi(1'b0);
          7: begin
            send_byte(BYTE_ESC);
            send_byte(SKIP_INTRO[$urandom_range(0, 7)*8 +: 8]);
            send_byte(8'($urandom));
          end
          8: begin
            send_byte(BYTE_ESC);
            if ($urandom_range(0, 1)) begin
              send_byte(BYTE_CSI);
              send_byte(INTER_LO + 8'($urandom_range(0, 15)));
              send_byte(PARAM_LO + 8'($urandom_range(0, 15)));
            end else begin
              send_byte(8'($urandom));
            end
          end
          default: send_byte(8'($urandom));
        endcase
      end
    end
  endtask

  // result side: compare each accepted beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_keys.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d char %02h",
                 $time, kind_o, char_out_o);
      end else begin
        oldest_key = expected_keys.pop_front();
        if (kind_o !== oldest_key.kind) begin
          errors++;
          $display("%0t: kind mismatch, expected %0d actual %0d",
                   $time, oldest_key.kind, kind_o);
        end
        if (char_out_o !== oldest_key.ch) begin
          errors++;
          $display("%0t: char mismatch, expected %02h actual %02h",
                   $time, oldest_key.ch, char_out_o);
        end
        results_checked++;
        if (oldest_key.kind != KIND_CHAR) keys_seen++;
      end
    end
  end

  // receiver stalls; a requested hold-off is counted out here
  initial begin
    int run;
    int holds_done;
    run         = 0;
    holds_done  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done  = holds_asked;
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else if (run > 0) begin
        out_stall_i = 1'b1;
        run--;
      end else begin
        out_stall_i = 1'b0;
        if (rx_idle) run = pick_gap();
      end
    end
  end

  initial begin
    int waited;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    byte_in_i       = 8'h00;
    parse_mode      = MODE_IDLE;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    holds_asked     = 0;
    errors          = 0;
    bytes_sent      = 0;
    results_checked = 0;
    keys_seen       = 0;
    stall_cycles    = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_plain_bytes();
    test_arrow_keys();
    test_odd_sequences();
    test_backpressure();
    test_random_stream();

    in_valid_i = 1'b0;
    rx_idle    = 1'b0;
    waited     = 0;
    while (expected_keys.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (expected_keys.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_keys.size());
    end

    $display("bytes sent %0d, results checked %0d, of which arrow keys %0d",
             bytes_sent, results_checked, keys_seen);
    $display("input held off for %0d cycles while the output was stalled", stall_cycles);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #8000000;
    $display("%0t: run timed out", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/vtkd_pkg.sv
hdl/vt100_escape_key_decoder.sv
tb/tb_vt100_escape_key_decoder.sv
